// File: rtl/core/ldpc_tbp_pkg.sv
// shared constants and types of the ldpc transport block parameter block
package ldpc_tbp_pkg;

    localparam int unsigned MAX_LIFT_INDEX = 50;
    localparam int unsigned NUM_LIFT       = 51;
    localparam int unsigned MAX_BLOCKS     = 511;

    // base graph codes
    localparam logic [1:0] BG_ONE = 2'd1;
    localparam logic [1:0] BG_TWO = 2'd2;

    // base graph selection thresholds
    localparam logic [9:0]  RATE_LOW     = 10'd256;
    localparam logic [9:0]  RATE_MID     = 10'd686;
    localparam logic [20:0] TB_SMALL     = 21'd292;
    localparam logic [20:0] TB_MID       = 21'd3824;
    localparam logic [20:0] CRC_BITS     = 21'd24;
    localparam logic [13:0] KCB_BG2      = 14'd3816;
    localparam logic [13:0] KCB_BG1      = 14'd8424;
    localparam logic [4:0]  COLS_BG1     = 5'd22;
    localparam logic [4:0]  COLS_BG2     = 5'd10;

    // block count by reciprocal: (tb+crc)/8 times m, shifted right by 30 (bg1) or 28 (bg2)
    localparam logic [19:0] RECIP_BG1    = 20'd1019698;   // 2^30 / 1053 rounded up
    localparam logic [19:0] RECIP_BG2    = 20'd562758;    // 2^28 / 477 rounded up

    // nr lifting sizes
    localparam logic [8:0] LIFT_Z [NUM_LIFT] = '{
        9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd12, 9'd13,
        9'd14, 9'd15, 9'd16, 9'd18, 9'd20, 9'd22, 9'd24, 9'd26, 9'd28, 9'd30, 9'd32,
        9'd36, 9'd40, 9'd44, 9'd48, 9'd52, 9'd56, 9'd60, 9'd64,
        9'd72, 9'd80, 9'd88, 9'd96, 9'd104, 9'd112, 9'd120, 9'd128,
        9'd144, 9'd160, 9'd176, 9'd192, 9'd208, 9'd224, 9'd240, 9'd256,
        9'd288, 9'd320, 9'd352, 9'd384
    };

    localparam int unsigned DIV_W = 32;

endpackage

// File: rtl/core/ldpc_tbp_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
module ldpc_tbp_div #(
    parameter int unsigned NUM_W  = ldpc_tbp_pkg::DIV_W,
    parameter int unsigned DEN_W  = 9,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    // index 0 is the input, index s+1 the register of stage s
    logic              a_vld  [NUM_W+1];
    logic [NUM_W-1:0]  a_num  [NUM_W+1];
    logic [DEN_W-1:0]  a_rem  [NUM_W+1];
    logic [DEN_W-1:0]  a_den  [NUM_W+1];
    logic [SIDE_W-1:0] a_side [NUM_W+1];

    logic              r_vld  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    assign a_vld[0]  = i_valid;
    assign a_num[0]  = i_num;
    assign a_rem[0]  = '0;
    assign a_den[0]  = i_den;
    assign a_side[0] = i_side;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0] n_trial;
        logic [DEN_W:0] n_diff;
        logic           n_ge;

        assign n_trial = {a_rem[s], a_num[s][NUM_W-1]};
        assign n_ge    = n_trial >= {1'b0, a_den[s]};
        assign n_diff  = n_trial - {1'b0, a_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= a_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s]  <= {a_num[s][NUM_W-2:0], n_ge};
                r_rem[s]  <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_den[s]  <= a_den[s];
                r_side[s] <= a_side[s];
            end
        end

        assign a_vld[s+1]  = r_vld[s];
        assign a_num[s+1]  = r_num[s];
        assign a_rem[s+1]  = r_rem[s];
        assign a_den[s+1]  = r_den[s];
        assign a_side[s+1] = r_side[s];
    end

    assign o_valid = a_vld[NUM_W];
    assign o_quot  = a_num[NUM_W];
    assign o_rem   = a_rem[NUM_W];
    assign o_side  = a_side[NUM_W];

endmodule

// File: rtl/core/ldpc_transport_block_params.sv
// top level of the ldpc transport block parameter block
// One transaction in per user, one transaction out per user, in order. The block picks the base
// graph, the code block count and size, the lifting-size index, the coded-bit budget g, the
// rate-matching lengths e and sample counts s, the e shift and the scrambling cinit. A new user
// can enter every cycle unless a held result stalls the pipeline. The path runs through three
// chained 32-stage restoring dividers (tb*1024/rate with the block count taken by a reciprocal
// multiply beside it, then block size, g/lq and g/(lq*c), then the modulo by c) plus four
// registers around them. Division by zero returns all ones. The input side keeps accepting
// while a result waits, until a valid item reaches the output of the last divider.
module ldpc_transport_block_params #(
    parameter int unsigned MAX_LIFT_INDEX = ldpc_tbp_pkg::MAX_LIFT_INDEX
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tb_size[20:0], code_rate[30:21], num_layers[33:31], mod_order[37:34], rnti[53:38],
    // num_codewords[55:54], scrambling_id[65:56], zero fill
    input  logic [71:0]  s_axis_tdata,
    input  logic         s_axis_tlast,   // last_user
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // base_graph[1:0], num_blocks[10:2], block_size[24:11], lift_index[30:25],
    // coded_bits[62:31], e_shift[71:63], e_small[103:72], e_large[135:104],
    // s_small[167:136], s_large[199:168], cinit[230:200], zero fill
    output logic [231:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_out
);

    localparam int unsigned DW = ldpc_tbp_pkg::DIV_W;

    logic w_en;

    // input field unpack
    logic [20:0] w_tb;
    logic [9:0]  w_rate;
    logic [2:0]  w_nl;
    logic [3:0]  w_q;
    logic [15:0] w_rnti;
    logic [1:0]  w_ncw;
    logic [9:0]  w_sid;

    assign w_tb   = s_axis_tdata[20:0];
    assign w_rate = s_axis_tdata[30:21];
    assign w_nl   = s_axis_tdata[33:31];
    assign w_q    = s_axis_tdata[37:34];
    assign w_rnti = s_axis_tdata[53:38];
    assign w_ncw  = s_axis_tdata[55:54];
    assign w_sid  = s_axis_tdata[65:56];

    // stage 0: base graph, tb+crc, layers times order, scrambling seed
    logic        n_bg1;
    logic [16:0] n_cw_m1;
    logic        r0_vld;
    logic        r0_bg1;
    logic [21:0] r0_tbp;
    logic [20:0] r0_tb;
    logic [9:0]  r0_rate;
    logic [6:0]  r0_lq;
    logic [2:0]  r0_nl;
    logic [30:0] r0_cinit;
    logic        r0_last;

    assign n_bg1 = !(w_rate <= ldpc_tbp_pkg::RATE_LOW || w_tb <= ldpc_tbp_pkg::TB_SMALL ||
                     (w_tb <= ldpc_tbp_pkg::TB_MID && w_rate <= ldpc_tbp_pkg::RATE_MID));
    // codeword count minus one wraps before the shift
    assign n_cw_m1 = {15'd0, w_ncw} - 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_bg1   <= n_bg1;
            // tb+crc can carry into a 22nd bit
            r0_tbp   <= {1'b0, w_tb} + {1'b0, ldpc_tbp_pkg::CRC_BITS};
            r0_tb    <= w_tb;
            r0_rate  <= w_rate;
            r0_lq    <= {4'd0, w_nl} * {3'd0, w_q};
            r0_nl    <= w_nl;
            r0_cinit <= {w_rnti, 15'd0} + {n_cw_m1, 14'd0} + {21'd0, w_sid};
            r0_last  <= s_axis_tlast;
        end
    end

    // phase 1: coded bit quotient, block count quotient rides along as side data
    localparam int unsigned SIDE1_W = 1 + 22 + 7 + 3 + 31 + 1 + 10;
    logic [38:0]        w_cprod;
    logic [9:0]         w_cq;
    logic               d1_vld;
    logic [DW-1:0]      d1_quot;
    logic [SIDE1_W-1:0] d1_side;

    // (tb+crc)/kcb as floor((tb+crc)/8) times a rounded-up reciprocal, exact for 22-bit input
    assign w_cprod = {20'd0, r0_tbp[21:3]} *
                     {19'd0, (r0_bg1 ? ldpc_tbp_pkg::RECIP_BG1 : ldpc_tbp_pkg::RECIP_BG2)};
    assign w_cq    = r0_bg1 ? {1'b0, w_cprod[38:30]} : w_cprod[37:28];

    ldpc_tbp_div #(.NUM_W(DW), .DEN_W(10), .SIDE_W(SIDE1_W)) u_div_coded (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_vld),
        .i_num   ({1'b0, r0_tb, 10'd0}),
        .i_den   (r0_rate),
        .i_side  ({r0_bg1, r0_tbp, r0_lq, r0_nl, r0_cinit, r0_last, w_cq}),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_rem   (),
        .o_side  (d1_side)
    );

    // stage 1: clamp block count, finish g, lq*c
    logic        r1_vld;
    logic        r1_bg1;
    logic [21:0] r1_tbp;
    logic [6:0]  r1_lq;
    logic [2:0]  r1_nl;
    logic [30:0] r1_cinit;
    logic        r1_last;
    logic [8:0]  r1_c;
    logic [31:0] r1_g;
    logic [8:0]  n_c;
    logic [9:0]  s1_cq;

    assign s1_cq = d1_side[9:0];

    // too many blocks holds at the largest 9-bit count
    assign n_c = (s1_cq >= 10'(ldpc_tbp_pkg::MAX_BLOCKS)) ? 9'(ldpc_tbp_pkg::MAX_BLOCKS)
                                                          : s1_cq[8:0] + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            {r1_bg1, r1_tbp, r1_lq, r1_nl, r1_cinit, r1_last} <= d1_side[SIDE1_W-1:10];
            r1_c <= n_c;
            r1_g <= d1_quot + 32'd1;
        end
    end

    // phase 2: block size, g/lq, g/(lq*c)
    localparam int unsigned SIDE2_W = 1 + 9 + 32 + 7 + 3 + 31 + 1;
    logic               d3_vld;
    logic [DW-1:0]      d3_quot;
    logic [SIDE2_W-1:0] d3_side;
    logic [DW-1:0]      d4_quot;
    logic [DW-1:0]      d6_quot;
    logic [15:0]        w_lqc;

    assign w_lqc = {9'd0, r1_lq} * {7'd0, r1_c};

    ldpc_tbp_div #(.NUM_W(DW), .DEN_W(9), .SIDE_W(SIDE2_W)) u_div_ksize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   ({10'd0, r1_tbp}),
        .i_den   (r1_c),
        .i_side  ({r1_bg1, r1_c, r1_g, r1_lq, r1_nl, r1_cinit, r1_last}),
        .o_valid (d3_vld),
        .o_quot  (d3_quot),
        .o_rem   (),
        .o_side  (d3_side)
    );

    ldpc_tbp_div #(.NUM_W(DW), .DEN_W(7), .SIDE_W(1)) u_div_symbols (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (r1_g),
        .i_den   (r1_lq),
        .i_side  (1'b0),
        .o_valid (),
        .o_quot  (d4_quot),
        .o_rem   (),
        .o_side  ()
    );

    ldpc_tbp_div #(.NUM_W(DW), .DEN_W(16), .SIDE_W(1)) u_div_perblock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (r1_g),
        .i_den   (w_lqc),
        .i_side  (1'b0),
        .o_valid (),
        .o_quot  (d6_quot),
        .o_rem   (),
        .o_side  ()
    );

    // stage 2: block size, symbol count plus one, e and s base values
    logic        r2_vld;
    logic        r2_bg1;
    logic [8:0]  r2_c;
    logic [31:0] r2_g;
    logic [6:0]  r2_lq;
    logic [2:0]  r2_nl;
    logic [30:0] r2_cinit;
    logic        r2_last;
    logic [13:0] r2_k;
    logic [31:0] r2_divg;
    logic [31:0] r2_esmall;
    logic [31:0] r2_ssmall;
    logic        s2_bg1;
    logic [8:0]  s2_c;
    logic [31:0] s2_g;
    logic [6:0]  s2_lq;
    logic [2:0]  s2_nl;
    logic [30:0] s2_cinit;
    logic        s2_last;

    assign {s2_bg1, s2_c, s2_g, s2_lq, s2_nl, s2_cinit, s2_last} = d3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_bg1    <= s2_bg1;
            r2_c      <= s2_c;
            r2_g      <= s2_g;
            r2_lq     <= s2_lq;
            r2_nl     <= s2_nl;
            r2_cinit  <= s2_cinit;
            r2_last   <= s2_last;
            r2_k      <= d3_quot[13:0] + 14'd24;
            r2_divg   <= d4_quot + 32'd1;
            r2_esmall <= {25'd0, s2_lq} * d6_quot;
            r2_ssmall <= {29'd0, s2_nl} * d6_quot;
        end
    end

    // phase 3: symbol count modulo block count
    localparam int unsigned SIDE3_W = 1 + 9 + 14 + 32 + 32 + 32 + 7 + 3 + 31 + 1;
    logic               d5_vld;
    logic [8:0]         d5_rem;
    logic [SIDE3_W-1:0] d5_side;

    ldpc_tbp_div #(.NUM_W(DW), .DEN_W(9), .SIDE_W(SIDE3_W)) u_div_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_num   (r2_divg),
        .i_den   (r2_c),
        .i_side  ({r2_bg1, r2_c, r2_k, r2_g, r2_esmall, r2_ssmall, r2_lq, r2_nl,
                   r2_cinit, r2_last}),
        .o_valid (d5_vld),
        .o_quot  (),
        .o_rem   (d5_rem),
        .o_side  (d5_side)
    );

    // output stage: e shift, large values, lifting index search
    logic        s3_bg1;
    logic [8:0]  s3_c;
    logic [13:0] s3_k;
    logic [31:0] s3_g;
    logic [31:0] s3_esmall;
    logic [31:0] s3_ssmall;
    logic [6:0]  s3_lq;
    logic [2:0]  s3_nl;
    logic [30:0] s3_cinit;
    logic        s3_last;
    logic [5:0]  n_lift;
    logic [4:0]  n_cols;
    logic [1:0]  n_bg;

    assign {s3_bg1, s3_c, s3_k, s3_g, s3_esmall, s3_ssmall, s3_lq, s3_nl, s3_cinit,
            s3_last} = d5_side;
    assign n_cols = s3_bg1 ? ldpc_tbp_pkg::COLS_BG1 : ldpc_tbp_pkg::COLS_BG2;
    assign n_bg   = s3_bg1 ? ldpc_tbp_pkg::BG_ONE : ldpc_tbp_pkg::BG_TWO;

    // smallest table entry that covers k, saturating at the top index
    always_comb begin
        n_lift = 6'(MAX_LIFT_INDEX);
        for (int j = MAX_LIFT_INDEX - 1; j >= 0; j--) begin
            if (({9'd0, n_cols} * {5'd0, ldpc_tbp_pkg::LIFT_Z[j]}) >= s3_k) begin
                n_lift = 6'(j);
            end
        end
    end

    logic         r_out_vld;
    logic [231:0] r_out_data;
    logic         r_out_last;

    // pipeline moves unless a full final stage meets a held result
    assign w_en = m_axis_tready || !r_out_vld || !d5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (m_axis_tready || !r_out_vld) begin
            r_out_vld <= d5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_vld) begin
            r_out_last <= s3_last;
            r_out_data <= {1'b0, s3_cinit,
                           s3_ssmall + {29'd0, s3_nl}, s3_ssmall,
                           s3_esmall + {25'd0, s3_lq}, s3_esmall,
                           s3_c - d5_rem, s3_g, n_lift, s3_k, s3_c, n_bg};
        end
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // checks on the result transaction
    a_bg_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ldpc_tbp_pkg::BG_ONE ||
                           m_axis_tdata[1:0] == ldpc_tbp_pkg::BG_TWO))
        else $error("base graph code out of range");

    a_blocks_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:2] != 9'd0)
        else $error("zero code blocks");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[71:63] != 9'd0 &&
                           m_axis_tdata[71:63] <= m_axis_tdata[10:2]))
        else $error("e shift outside one to block count");

    a_lift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:25] <= 6'(MAX_LIFT_INDEX))
        else $error("lifting index beyond table");

    a_accept_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule
